FILE: sv/fol_pkg.sv
package fol_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int PAGE_BITS  = 20;
   localparam int CNT_W      = 32;
   localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
   localparam int CSR_W      = 5;

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic CSR_LRU_MODE = 1'b0;
   localparam logic CSR_FRAMES   = 1'b1;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // running search record handed from cell to cell
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] hit_slot;
      logic              empty;
      logic [SLOT_W-1:0] empty_slot;
      logic              min_valid;
      logic [CNT_W-1:0]  min_step;
      logic [SLOT_W-1:0] min_slot;
   } scan_type;

   // update broadcast from the controller to every cell
   typedef struct packed {
      logic                 clr;
      logic                 wr;
      logic                 set_page;
      logic [SLOT_W-1:0]    slot;
      logic [PAGE_BITS-1:0] page;
      logic [CNT_W-1:0]     step;
   } upd_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

FILE: sv/fol_cell.sv
module fol_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fol_pkg::SLOT_W-1:0]    cell_idx,
   input  logic [fol_pkg::COUNT_W-1:0]   n_active,
   input  logic [fol_pkg::PAGE_BITS-1:0] key_page,
   input  fol_pkg::scan_type             scan_in,
   output fol_pkg::scan_type             scan_out,
   input  fol_pkg::upd_type              upd,
   output logic [fol_pkg::PAGE_BITS-1:0] page_out,
   output logic                          full_out
);
   import fol_pkg::*;

   logic [PAGE_BITS-1:0] page_ff;
   logic                 full_ff;
   logic [CNT_W-1:0]     last_use_ff;
   scan_type             scan_ff;
   scan_type             scan_in_rec;
   logic                 active;

   assign active = COUNT_W'(cell_idx) < n_active;

   always_comb begin
      scan_in_rec = scan_in;
      if (active) begin
         if (full_ff && (page_ff == key_page) && !scan_in.hit) begin
            scan_in_rec.hit      = 1'b1;
            scan_in_rec.hit_slot = cell_idx;
         end
         if (!full_ff && !scan_in.empty) begin
            scan_in_rec.empty      = 1'b1;
            scan_in_rec.empty_slot = cell_idx;
         end
         // strict less keeps the lowest index on ties
         if (!scan_in.min_valid || (last_use_ff < scan_in.min_step)) begin
            scan_in_rec.min_valid = 1'b1;
            scan_in_rec.min_step  = last_use_ff;
            scan_in_rec.min_slot  = cell_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in_rec;
   end

   always_ff @(posedge clock) begin
      if (reset || upd.clr) begin
         page_ff     <= '0;
         full_ff     <= 1'b0;
         last_use_ff <= '0;
      end else if (upd.wr && (upd.slot == cell_idx)) begin
         last_use_ff <= upd.step;
         if (upd.set_page) begin
            page_ff <= upd.page;
            full_ff <= 1'b1;
         end
      end
   end

   assign scan_out = scan_ff;
   assign page_out = page_ff;
   assign full_out = full_ff;

endmodule

FILE: sv/fifo_or_lru_page_replacement.sv
// channel  direction  ports
// req      in         req_valid, req_ready, req_opcode, req_page_number
// rsp      out        rsp_valid, rsp_ready, rsp_was_hit ... rsp_fault_total
// csr      in         csr_we, csr_index, csr_wdata
//
// an access latches the page, lets the search record ripple through the row of frame
// cells, then decides and writes the chosen frame; a clear skips the ripple and goes
// straight from the latch to the decide step
// one item is in flight at a time; the next is taken while a result beat waits
// in the output register, and the decide cycle holds until that register frees
// reset empties every frame, zeroes the counters and sets FIFO mode, 3 frames
module fifo_or_lru_page_replacement (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [fol_pkg::PAGE_BITS-1:0] req_page_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_was_hit,
   output logic [3:0]                    rsp_frame_slot,
   output logic                          rsp_evict_valid,
   output logic [fol_pkg::PAGE_BITS-1:0] rsp_evicted_page,
   output logic [fol_pkg::CNT_W-1:0]     rsp_step_number,
   output logic [fol_pkg::CNT_W-1:0]     rsp_hit_total,
   output logic [fol_pkg::CNT_W-1:0]     rsp_fault_total,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [fol_pkg::CSR_W-1:0]     csr_wdata
);
   import fol_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE} state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   cnt_ff;
   logic                 op_ff;
   logic [PAGE_BITS-1:0] key_ff;
   logic                 lru_mode_ff;
   logic [CSR_W-1:0]     frames_ff;
   logic [SLOT_W-1:0]    fifo_ptr_ff;
   logic [SLOT_W-1:0]    fifo_ptr_in;
   logic [CNT_W-1:0]     acc_ff;
   logic [CNT_W-1:0]     hit_ff;
   logic [CNT_W-1:0]     fault_ff;
   logic [CNT_W-1:0]     acc_in;

   logic                 rsp_valid_ff;
   logic                 was_hit_ff;
   logic [3:0]           slot_ff;
   logic                 evict_ff;
   logic [PAGE_BITS-1:0] evicted_ff;
   logic [CNT_W-1:0]     step_ff;
   logic [CNT_W-1:0]     hit_tot_ff;
   logic [CNT_W-1:0]     fault_tot_ff;

   logic [COUNT_W-1:0]   n_active;
   scan_type             scan_chain [MAX_FRAMES+1];
   logic [PAGE_BITS-1:0] cell_page [MAX_FRAMES];
   logic                 cell_full [MAX_FRAMES];
   upd_type              upd;
   logic                 out_free;
   logic                 go;
   scan_type             rec;
   logic [SLOT_W-1:0]    slot;
   logic [SLOT_W-1:0]    fifo_slot;
   logic                 evict;

   always_comb begin
      if (frames_ff == '0) begin
         n_active = COUNT_W'(1);
      end else if (32'(frames_ff) > MAX_FRAMES) begin
         n_active = COUNT_W'(MAX_FRAMES);
      end else begin
         n_active = COUNT_W'(frames_ff);
      end
   end

   assign scan_chain[0] = '0;

   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      fol_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (SLOT_W'(g)),
         .n_active (n_active),
         .key_page (key_ff),
         .scan_in  (scan_chain[g]),
         .scan_out (scan_chain[g+1]),
         .upd      (upd),
         .page_out (cell_page[g]),
         .full_out (cell_full[g])
      );
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign go        = (state_ff == ST_DECIDE) && out_free;
   assign req_ready = (state_ff == ST_IDLE);
   assign rec       = scan_chain[MAX_FRAMES];
   assign acc_in    = sat_inc(acc_ff);

   always_comb begin
      // a pointer left beyond a shrunk frame count restarts at frame 0
      fifo_slot = (COUNT_W'(fifo_ptr_ff) >= n_active) ? '0 : fifo_ptr_ff;
      fifo_ptr_in = ((COUNT_W'(fifo_slot) + 1'b1) >= n_active) ? '0 : fifo_slot + 1'b1;
      if (rec.hit) begin
         slot = rec.hit_slot;
      end else if (lru_mode_ff) begin
         slot = rec.empty ? rec.empty_slot : rec.min_slot;
      end else begin
         slot = fifo_slot;
      end
      evict = !rec.hit && cell_full[slot];
   end

   always_comb begin
      upd          = '0;
      upd.clr      = go && (op_ff == OP_CLEAR);
      upd.wr       = go && (op_ff == OP_ACCESS);
      upd.set_page = !rec.hit;
      upd.slot     = slot;
      upd.page     = key_ff;
      upd.step     = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lru_mode_ff <= 1'b0;
         frames_ff   <= CSR_W'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LRU_MODE: lru_mode_ff <= csr_wdata[0];
            CSR_FRAMES:   frames_ff   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fifo_ptr_ff  <= '0;
         acc_ff       <= '0;
         hit_ff       <= '0;
         fault_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_opcode;
                  key_ff   <= req_page_number;
                  cnt_ff   <= '0;
                  state_ff <= (req_opcode == OP_CLEAR) ? ST_DECIDE : ST_SCAN;
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == COUNT_W'(MAX_FRAMES - 1)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (op_ff == OP_CLEAR) begin
                     fifo_ptr_ff  <= '0;
                     acc_ff       <= '0;
                     hit_ff       <= '0;
                     fault_ff     <= '0;
                     was_hit_ff   <= 1'b0;
                     slot_ff      <= '0;
                     evict_ff     <= 1'b0;
                     evicted_ff   <= '0;
                     step_ff      <= '0;
                     hit_tot_ff   <= '0;
                     fault_tot_ff <= '0;
                  end else begin
                     acc_ff       <= acc_in;
                     step_ff      <= acc_in;
                     was_hit_ff   <= rec.hit;
                     slot_ff      <= 4'(slot);
                     evict_ff     <= evict;
                     evicted_ff   <= evict ? cell_page[slot] : '0;
                     hit_tot_ff   <= rec.hit ? sat_inc(hit_ff) : hit_ff;
                     fault_tot_ff <= rec.hit ? fault_ff : sat_inc(fault_ff);
                     if (rec.hit) begin
                        hit_ff <= sat_inc(hit_ff);
                     end else begin
                        fault_ff <= sat_inc(fault_ff);
                        if (!lru_mode_ff) begin
                           fifo_ptr_ff <= fifo_ptr_in;
                        end
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_hit      = was_hit_ff;
   assign rsp_frame_slot   = slot_ff;
   assign rsp_evict_valid  = evict_ff;
   assign rsp_evicted_page = evicted_ff;
   assign rsp_step_number  = step_ff;
   assign rsp_hit_total    = hit_tot_ff;
   assign rsp_fault_total  = fault_tot_ff;

`ifndef SYNTH
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_hit |-> !rsp_evict_valid)
      else $error("hit beat reports an eviction");

   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evict_valid |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without eviction");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      upd.wr |-> COUNT_W'(upd.slot) < n_active)
      else $error("frame write beyond active frames");

   a_decide_after_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && cnt_ff == COUNT_W'(MAX_FRAMES - 1) |=> state_ff == ST_DECIDE)
      else $error("sweep did not end in decide");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import fol_pkg::*;

   localparam int unsigned RUN_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYC  = MAX_FRAMES + 8;
   localparam int          POOL_DEPTH  = 24;

   typedef struct packed {
      logic                 op;
      logic [PAGE_BITS-1:0] page;
   } page_ref_type;

   typedef struct packed {
      logic                 hit;
      logic [3:0]           slot;
      logic                 evict;
      logic [PAGE_BITS-1:0] victim;
      logic [CNT_W-1:0]     step;
      logic [CNT_W-1:0]     hits;
      logic [CNT_W-1:0]     faults;
   } page_rsp_type;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic                 req_opcode      = OP_ACCESS;
   logic [PAGE_BITS-1:0] req_page_number = '0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic                 rsp_was_hit;
   logic [3:0]           rsp_frame_slot;
   logic                 rsp_evict_valid;
   logic [PAGE_BITS-1:0] rsp_evicted_page;
   logic [CNT_W-1:0]     rsp_step_number;
   logic [CNT_W-1:0]     rsp_hit_total;
   logic [CNT_W-1:0]     rsp_fault_total;
   logic                 csr_we          = 1'b0;
   logic                 csr_index       = CSR_LRU_MODE;
   logic [CSR_W-1:0]     csr_wdata       = '0;

   fifo_or_lru_page_replacement u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_was_hit      (rsp_was_hit),
      .rsp_frame_slot   (rsp_frame_slot),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_step_number  (rsp_step_number),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_fault_total  (rsp_fault_total),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // shadow copy of the frame table
   logic                 cfg_lru    = 1'b0;
   logic [CSR_W-1:0]     cfg_frames = 5'd3;
   logic [PAGE_BITS-1:0] frm_page [MAX_FRAMES];
   logic                 frm_full [MAX_FRAMES];
   logic [CNT_W-1:0]     frm_used [MAX_FRAMES];
   int                   fifo_ptr;
   logic [CNT_W-1:0]     step_cnt, hit_cnt, fault_cnt;

   page_ref_type ref_backlog[$];
   page_rsp_type owed_rsps[$];

   int unsigned sender_idle_pct = 0;
   int unsigned recv_stall_pct  = 0;
   int unsigned mismatch_count  = 0;
   int unsigned stray_count     = 0;
   int unsigned cycle_count     = 0;

   logic [PAGE_BITS-1:0] page_pool [POOL_DEPTH];
   int                   pool_n;

   function automatic void wipe_frames();
      int i;
      for (i = 0; i < MAX_FRAMES; i++) begin
         frm_page[i] = '0;
         frm_full[i] = 1'b0;
         frm_used[i] = '0;
      end
      fifo_ptr  = 0;
      step_cnt  = '0;
      hit_cnt   = '0;
      fault_cnt = '0;
   endfunction

   function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic int live_frames();
      if (cfg_frames == 0)
         return 1;
      if (cfg_frames > MAX_FRAMES)
         return MAX_FRAMES;
      return int'(cfg_frames);
   endfunction

   function automatic page_rsp_type replace_page(page_ref_type r);
      page_rsp_type res;
      int           n, slot, i;
      bit           found, has_empty;
      res = '0;
      if (r.op == OP_CLEAR) begin
         wipe_frames();
         return res;
      end
      n = live_frames();
      step_cnt = bump(step_cnt);
      found = 1'b0;
      slot  = 0;
      for (i = 0; i < n; i++)
         if (!found && frm_full[i] && frm_page[i] == r.page) begin
            slot  = i;
            found = 1'b1;
         end
      if (found) begin
         hit_cnt = bump(hit_cnt);
      end else begin
         fault_cnt = bump(fault_cnt);
         if (cfg_lru) begin
            has_empty = 1'b0;
            for (i = 0; i < n; i++)
               if (!has_empty && !frm_full[i]) begin
                  slot      = i;
                  has_empty = 1'b1;
               end
            if (!has_empty) begin
               slot = 0;
               for (i = 1; i < n; i++)
                  if (frm_used[i] < frm_used[slot])
                     slot = i;
            end
         end else begin
            // pointer left beyond a shrunken table starts over
            if (fifo_ptr >= n)
               fifo_ptr = 0;
            slot     = fifo_ptr;
            fifo_ptr = (fifo_ptr + 1 >= n) ? 0 : fifo_ptr + 1;
         end
         if (frm_full[slot]) begin
            res.evict  = 1'b1;
            res.victim = frm_page[slot];
         end
         frm_page[slot] = r.page;
         frm_full[slot] = 1'b1;
      end
      frm_used[slot] = step_cnt;
      res.hit    = found;
      res.slot   = 4'(slot);
      res.step   = step_cnt;
      res.hits   = hit_cnt;
      res.faults = fault_cnt;
      return res;
   endfunction

   // request driver
   page_ref_type drv_next;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            owed_rsps.push_back(replace_page('{op: req_opcode, page: req_page_number}));
         if (req_valid && !req_ready) begin
            // beat still waiting, hold it
         end else if (ref_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            drv_next = ref_backlog.pop_front();
            req_valid       <= 1'b1;
            req_opcode      <= drv_next.op;
            req_page_number <= drv_next.page;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   page_rsp_type rsp_seen, rsp_want;
   assign rsp_seen = {rsp_was_hit, rsp_frame_slot, rsp_evict_valid, rsp_evicted_page,
                      rsp_step_number, rsp_hit_total, rsp_fault_total};

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_rsps.size() == 0) begin
               stray_count++;
               $display("unexpected result beat: hit=%0d slot=%0d step=%0d",
                        rsp_was_hit, rsp_frame_slot, rsp_step_number);
            end else begin
               rsp_want = owed_rsps.pop_front();
               if (rsp_seen !== rsp_want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: exp hit=%0d slot=%0d ev=%0d vic=%h step=%0d",
                               " hits=%0d faults=%0d | got hit=%0d slot=%0d ev=%0d vic=%h",
                               " step=%0d hits=%0d faults=%0d"},
                              rsp_want.hit, rsp_want.slot, rsp_want.evict, rsp_want.victim,
                              rsp_want.step, rsp_want.hits, rsp_want.faults,
                              rsp_seen.hit, rsp_seen.slot, rsp_seen.evict, rsp_seen.victim,
                              rsp_seen.step, rsp_seen.hits, rsp_seen.faults);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic add_ref(logic op, logic [PAGE_BITS-1:0] page);
      ref_backlog.push_back('{op: op, page: page});
   endtask

   task automatic wait_drained();
      while (!(ref_backlog.size() == 0 && !req_valid && owed_rsps.size() == 0))
         @(negedge clock);
   endtask

   // block must be idle; the table is only touched at the write edge
   task automatic write_csr(logic idx, logic [CSR_W-1:0] val);
      wait_drained();
      repeat (SETTLE_CYC) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LRU_MODE)
         cfg_lru = val[0];
      else
         cfg_frames = val;
      @(negedge clock);
   endtask

   task automatic add_random_refs(int count);
      int          k;
      int unsigned r;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 3)
            add_ref(OP_CLEAR, PAGE_BITS'($urandom));
         else if (r < 88)
            add_ref(OP_ACCESS, page_pool[$urandom_range(pool_n - 1)]);
         else if (r < 96)
            add_ref(OP_ACCESS, PAGE_BITS'($urandom));
         else
            add_ref(OP_ACCESS, $urandom_range(1) ? '1 : '0);
      end
   endtask

   task automatic random_phase(logic lru, logic [CSR_W-1:0] frames,
                               int unsigned idle, int unsigned stall, int count);
      int i;
      write_csr(CSR_LRU_MODE, {{(CSR_W-1){1'b0}}, lru});
      write_csr(CSR_FRAMES, frames);
      // working set a little larger than the table so hits and faults mix
      pool_n = live_frames() + $urandom_range(1, 5);
      if (pool_n > POOL_DEPTH)
         pool_n = POOL_DEPTH;
      for (i = 0; i < POOL_DEPTH; i++)
         page_pool[i] = PAGE_BITS'($urandom);
      if ($urandom_range(3) == 0)
         page_pool[0] = '1;
      sender_idle_pct = idle;
      recv_stall_pct  = stall;
      add_random_refs(count / 2);
      // sender holds off until the block has answered everything
      wait_drained();
      add_random_refs(count - count / 2);
      wait_drained();
   endtask

   initial begin
      wipe_frames();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fifo, three frames from reset
      add_ref(OP_ACCESS, '0);
      add_ref(OP_ACCESS, '1);
      add_ref(OP_ACCESS, '0);
      add_ref(OP_ACCESS, 20'h00001);
      add_ref(OP_ACCESS, 20'h00002);
      add_ref(OP_CLEAR,  20'h5A5A5);
      add_ref(OP_ACCESS, '1);

      // lru over four frames, fill then evict the oldest
      write_csr(CSR_LRU_MODE, 5'd1);
      write_csr(CSR_FRAMES, 5'd4);
      add_ref(OP_ACCESS, 20'h00010);
      add_ref(OP_ACCESS, 20'h00011);
      add_ref(OP_ACCESS, 20'h00012);
      add_ref(OP_ACCESS, '1);
      add_ref(OP_ACCESS, 20'h00013);

      // shrink mid-trace: upper frames drop out of lookup
      write_csr(CSR_FRAMES, 5'd2);
      add_ref(OP_ACCESS, 20'h00012);
      add_ref(OP_ACCESS, 20'h00013);

      // zero frames behaves as one
      write_csr(CSR_LRU_MODE, 5'd0);
      write_csr(CSR_FRAMES, 5'd0);
      add_ref(OP_ACCESS, 20'h00007);
      add_ref(OP_ACCESS, 20'h00007);
      add_ref(OP_ACCESS, 20'h00008);

      // oversized count clamps to the full table
      write_csr(CSR_FRAMES, 5'd31);
      add_ref(OP_ACCESS, 20'h80000);
      add_ref(OP_ACCESS, 20'h7FFFF);
      add_ref(OP_ACCESS, 20'h55555);
      add_ref(OP_ACCESS, 20'hAAAAA);

      // fifo pointer now past the new count, wraps to frame 0
      write_csr(CSR_FRAMES, 5'd2);
      add_ref(OP_ACCESS, 20'h12345);
      add_ref(OP_CLEAR,  '1);
      wait_drained();

      random_phase(1'b1, 5'd16,  0,  0, 105);
      random_phase(1'b0, 5'd16, 52,  0, 105);
      random_phase(1'b1, 5'd1,   0, 52, 105);
      random_phase(1'b0, 5'd0,  21, 21, 105);
      random_phase(1'b1, 5'd31,  0,  0, 105);
      random_phase(1'b0, 5'd7,  52,  0, 105);
      random_phase(1'b1, 5'd5,   0, 52, 105);
      random_phase(1'b1, 5'd12, 21, 21, 105);

      repeat (SETTLE_CYC * 2) @(posedge clock);
      if (mismatch_count == 0 && stray_count == 0 && owed_rsps.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: fifo_or_lru_page_replacement.f
sv/fol_pkg.sv
sv/fol_cell.sv
sv/fifo_or_lru_page_replacement.sv
tb/tb_top.sv
